FILE: hdl/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and constants for the binary min-heap core.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_APPEND  = 2'd2,
        KIND_HEAPIFY = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

FILE: hdl/bmh_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_req_if
// Request channel: operation kind and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmh_req_if;
    import bmh_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    key_t  key_in;

    modport source (output valid, output kind, output key_in, input ready);
    modport sink   (input valid, input kind, input key_in, output ready);
endinterface

FILE: hdl/bmh_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_rsp_if
// Response channel: extracted key, status and fill level.
// FILL_W must equal $clog2(CAPACITY + 1) of the core it attaches to.
// ----------------------------------------------------------------------------
interface bmh_rsp_if #(
    parameter int FILL_W = 7
);
    import bmh_pkg::*;

    logic              valid;
    logic              ready;
    key_t              key_out;
    status_t           status;
    logic [FILL_W-1:0] fill;

    modport source (output valid, output key_out, output status, output fill, input ready);
    modport sink   (input valid, input key_out, input status, input fill, output ready);
endinterface

FILE: hdl/bmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/binary_min_heap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_core
// Fixed-capacity binary min-heap of signed 32-bit keys: insert, extract-min,
// append without sift, and bottom-up heapify.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  req      in   valid/ready   kind, key_in
//  rsp      out  valid/ready   key_out, status, fill
//
//  One request at a time; req.ready is high only in IDLE. Append, a full or
//  empty refusal, a heapify of fewer than two keys and an insert into an
//  empty heap go straight to RESP; insert otherwise sifts up, extract reads
//  the root and the last key and, with two or more keys left, sifts down,
//  and heapify sifts down each internal node from the last to the root.
//  The single RAM read port paces the sifts: one read per level on sift-up,
//  two (left, right child) per level on sift-down.
//  Reset clears the fill count and the control state; RAM contents are
//  left undefined and are only ever read below the fill count.
//  A finished response is held in an output register while rsp is stalled;
//  the next request is still taken, and its response waits in RESP until
//  that register frees up.
// ----------------------------------------------------------------------------
module binary_min_heap_core #(
    parameter int CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    bmh_req_if.sink   req,
    bmh_rsp_if.source rsp
);
    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);      // heap index width
    localparam int CW = $clog2(CAPACITY + 1);  // fill count width
    localparam int EW = AW + 2;                // child index width (up to 2*CAPACITY)

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SU_CMP = 12'b0000_0000_0010,
        S_WR_CUR = 12'b0000_0000_0100,
        S_EX_B   = 12'b0000_0000_1000,
        S_EX_C   = 12'b0000_0001_0000,
        S_EX_D   = 12'b0000_0010_0000,
        S_HP_RD  = 12'b0000_0100_0000,
        S_HP_CUR = 12'b0000_1000_0000,
        S_SD_R   = 12'b0001_0000_0000,
        S_SD_CMP = 12'b0010_0000_0000,
        S_RESP   = 12'b0100_0000_0000,
        S_SPARE  = 12'b1000_0000_0000
    } state_t;

    // control
    state_t        state_reg,     state_next;
    logic [CW-1:0] count_reg,     count_next;
    logic          heapify_reg,   heapify_next;
    logic          rsp_valid_reg, rsp_valid_next;
    // datapath
    logic [AW-1:0] pos_reg,       pos_next;
    logic [AW-1:0] hp_reg,        hp_next;
    key_t          cur_reg,       cur_next;
    key_t          lkey_reg,      lkey_next;
    key_t          key_out_reg,   key_out_next;
    status_t       status_reg,    status_next;
    key_t          rsp_key_reg,   rsp_key_next;
    status_t       rsp_status_reg, rsp_status_next;
    logic [CW-1:0] rsp_fill_reg,  rsp_fill_next;

    // RAM port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_rdata;
    key_t             rd_key;

    // index arithmetic
    logic [AW-1:0] cnt_idx, cnt_up, pos_up, up_up, sel_idx;
    logic [EW-1:0] l_ext, r_ext, n_ext, l2_ext;
    logic          has_r, sel_r, sd_stop;
    key_t          min_key;

    bmh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_key = key_t'(mem_rdata);

    // parent of the slot an insert lands in, and of the sift-up hole
    assign cnt_idx = count_reg[AW-1:0];
    assign cnt_up  = (cnt_idx - AW'(1)) >> 1;
    assign pos_up  = (pos_reg - AW'(1)) >> 1;
    assign up_up   = (pos_up - AW'(1)) >> 1;

    // children of the sift-down hole
    assign l_ext  = {1'b0, pos_reg, 1'b1};
    assign r_ext  = l_ext + EW'(1);
    assign n_ext  = EW'(count_reg);
    assign has_r  = (r_ext < n_ext);
    // left child wins a tie
    assign sel_r  = has_r && (lkey_reg > rd_key);
    assign min_key = sel_r ? rd_key : lkey_reg;
    assign sel_idx = sel_r ? r_ext[AW-1:0] : l_ext[AW-1:0];
    assign l2_ext = {1'b0, sel_idx, 1'b1};
    assign sd_stop = (cur_reg <= min_key);

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.key_out = rsp_key_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.fill    = rsp_fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        heapify_next    = heapify_reg;
        pos_next        = pos_reg;
        hp_next         = hp_reg;
        cur_next        = cur_reg;
        lkey_next       = lkey_reg;
        key_out_next    = key_out_reg;
        status_next     = status_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_status_next = rsp_status_reg;
        rsp_fill_next   = rsp_fill_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = cur_reg;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_out_next = '0;
                    status_next  = STATUS_OK;
                    heapify_next = 1'b0;
                    case (req.kind)
                        KIND_INSERT, KIND_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                pos_next   = cnt_idx;
                                cur_next   = req.key_in;
                                if (req.kind == KIND_APPEND || count_reg == '0)
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = cnt_idx;
                                    mem_wdata  = req.key_in;
                                    state_next = S_RESP;
                                end
                                else
                                begin
                                    mem_raddr  = cnt_up;
                                    state_next = S_SU_CMP;
                                end
                            end
                        end
                        KIND_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                mem_raddr  = '0;
                                state_next = S_EX_B;
                            end
                        end
                        KIND_HEAPIFY:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                heapify_next = 1'b1;
                                hp_next      = AW'((count_reg >> 1) - CW'(1));
                                state_next   = S_HP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // sift-up: hole at pos_reg, parent key on the read port
            S_SU_CMP:
            begin
                mem_we = 1'b1;
                if (rd_key <= cur_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_up;
                    if (pos_up == '0)
                    begin
                        state_next = S_WR_CUR;
                    end
                    else
                    begin
                        mem_raddr = up_up;
                    end
                end
            end

            S_WR_CUR:
            begin
                mem_we = 1'b1;
                if (heapify_reg && hp_reg != '0)
                begin
                    hp_next    = hp_reg - AW'(1);
                    state_next = S_HP_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // extract: root is on the read port; fetch the last key
            // (count already decremented)
            S_EX_B:
            begin
                key_out_next = rd_key;
                mem_raddr    = cnt_idx;
                state_next   = S_EX_C;
            end

            S_EX_C:
            begin
                mem_raddr  = cnt_idx;
                state_next = S_EX_D;
            end

            S_EX_D:
            begin
                cur_next = rd_key;
                pos_next = '0;
                if (count_reg >= CW'(2))
                begin
                    mem_raddr  = AW'(1);
                    state_next = S_SD_R;
                end
                else
                begin
                    if (count_reg == CW'(1))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = mem_rdata;
                    end
                    state_next = S_RESP;
                end
            end

            // heapify: load the next internal node, then sift it down
            S_HP_RD:
            begin
                mem_raddr  = hp_reg;
                pos_next   = hp_reg;
                state_next = S_HP_CUR;
            end

            S_HP_CUR:
            begin
                cur_next   = rd_key;
                mem_raddr  = l_ext[AW-1:0];
                state_next = S_SD_R;
            end

            S_SD_R:
            begin
                lkey_next = rd_key;
                if (has_r)
                begin
                    mem_raddr = r_ext[AW-1:0];
                end
                state_next = S_SD_CMP;
            end

            S_SD_CMP:
            begin
                mem_we = 1'b1;
                if (sd_stop)
                begin
                    if (heapify_reg && hp_reg != '0)
                    begin
                        hp_next    = hp_reg - AW'(1);
                        state_next = S_HP_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    mem_wdata = min_key;
                    pos_next  = sel_idx;
                    if (l2_ext < n_ext)
                    begin
                        mem_raddr  = l2_ext[AW-1:0];
                        state_next = S_SD_R;
                    end
                    else
                    begin
                        state_next = S_WR_CUR;
                    end
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_key_next    = key_out_reg;
                    rsp_status_next = status_reg;
                    rsp_fill_next   = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            heapify_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            heapify_reg   <= heapify_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        hp_reg         <= hp_next;
        cur_reg        <= cur_next;
        lkey_reg       <= lkey_next;
        key_out_reg    <= key_out_next;
        status_reg     <= status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_status_reg <= rsp_status_next;
        rsp_fill_reg   <= rsp_fill_next;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_min_heap_core. Requests go in through the
// req channel, and a local copy of the heap works out the response each one
// should produce. Responses are matched in order against that copy, under
// random sender gaps, random receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import bmh_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int FILL_W         = $clog2(CAPACITY + 1);
    localparam int WATCHDOG_LIMIT = 4000;   // well above the worst full-heap heapify
    localparam int DRAIN_CYCLES   = 250;
    localparam int REPORT_LIMIT   = 10;

    // One response as the core should return it.
    typedef struct packed {
        key_t              key_out;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bmh_req_if                     req_if ();
    bmh_rsp_if #(.FILL_W(FILL_W))  rsp_if ();

    binary_min_heap_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Shadow heap: keys and fill count, updated in request order.
    // ------------------------------------------------------------------------
    key_t         heap_keys [CAPACITY];
    int unsigned  heap_count = 0;

    heap_result_t expected_results [$];

    int           mismatch_count   = 0;
    int           sender_idle_pct  = 0;
    int           receiver_stall_pct = 0;
    int unsigned  rsp_hold_request = 0;
    int unsigned  quiet_cycles     = 0;

    function automatic void heap_swap(int unsigned a, int unsigned b);
        key_t tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    // Move a key toward the root while its parent is strictly larger.
    function automatic void heap_sift_up(int unsigned pos);
        int unsigned parent;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (heap_keys[parent] <= heap_keys[pos])
                break;
            heap_swap(parent, pos);
            pos = parent;
        end
    endfunction

    // Move a key toward the leaves; on equal children the left one wins,
    // and an equal child never causes a swap.
    function automatic void heap_sift_down(int unsigned pos, int unsigned n);
        int unsigned left;
        int unsigned pick;
        while (pos < n)
        begin
            left = 2 * pos + 1;
            if (left >= n)
                break;
            pick = left;
            if (left + 1 < n && heap_keys[left] > heap_keys[left + 1])
                pick = left + 1;
            if (heap_keys[pos] <= heap_keys[pick])
                break;
            heap_swap(pos, pick);
            pos = pick;
        end
    endfunction

    // Apply one request to the shadow heap and return the response it causes.
    function automatic heap_result_t heap_apply(kind_t kind, key_t key);
        heap_result_t res;
        int unsigned  node;
        res.key_out = '0;
        res.status  = STATUS_OK;
        case (kind)
            KIND_INSERT, KIND_APPEND:
            begin
                if (heap_count >= CAPACITY)
                    res.status = STATUS_FULL;   // key dropped, heap untouched
                else
                begin
                    heap_keys[heap_count] = key;
                    heap_count++;
                    if (kind == KIND_INSERT)
                        heap_sift_up(heap_count - 1);
                end
            end
            KIND_EXTRACT:
            begin
                if (heap_count == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.key_out = heap_keys[0];
                    heap_count--;
                    heap_keys[0] = heap_keys[heap_count];
                    heap_sift_down(0, heap_count);
                end
            end
            default:
            begin
                // Bottom-up rebuild; fewer than two keys leaves nothing to do.
                node = heap_count / 2;
                while (node > 0)
                begin
                    node--;
                    heap_sift_down(node, heap_count);
                end
            end
        endcase
        res.fill = heap_count[FILL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Every call starts and ends on a rising edge. valid is
    // only lowered in an idle cycle, so back-to-back requests never see a
    // low/high pair of assignments in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input kind_t kind, input key_t key);
        heap_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_if.valid  <= 1'b0;
            req_if.kind   <= kind_t'($urandom_range(3));    // noise on an idle bus
            req_if.key_in <= key_t'($urandom);
            @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.key_in <= key;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        // Accepted at this edge: predict now, in request order.
        predicted = heap_apply(kind, key);
        expected_results.push_back(predicted);
    endtask

    // Stop offering requests until every pending response has come back.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Mostly full-range keys, with a share of small values for duplicates
    // and a share of the extremes.
    function automatic key_t random_key();
        key_t key;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       key = 32'sh8000_0000;
                    1:       key = 32'sh7FFF_FFFF;
                    2:       key = '0;
                    default: key = '1;
                endcase
            end
            1, 2, 3: key = key_t'(int'($urandom_range(15)) - 8);
            default: key = key_t'($urandom);
        endcase
        return key;
    endfunction

    // Growing mix fills the heap; shrinking mix drains it toward empty.
    function automatic kind_t random_kind(input bit grow);
        int unsigned roll;
        roll = $urandom_range(99);
        if (grow)
        begin
            if (roll < 45)
                return KIND_INSERT;
            else if (roll < 75)
                return KIND_APPEND;
            else if (roll < 95)
                return KIND_EXTRACT;
            else
                return KIND_HEAPIFY;
        end
        else
        begin
            if (roll < 10)
                return KIND_INSERT;
            else if (roll < 15)
                return KIND_APPEND;
            else if (roll < 95)
                return KIND_EXTRACT;
            else
                return KIND_HEAPIFY;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extract and heapify on an empty heap, heapify on a single key.
    task automatic test_empty_heap();
        send_request(KIND_EXTRACT, '0);
        send_request(KIND_HEAPIFY, '0);
        send_request(KIND_APPEND, 32'sd5);
        send_request(KIND_HEAPIFY, '0);
        send_request(KIND_EXTRACT, '0);
        send_request(KIND_EXTRACT, '1);
    endtask

    // Most negative and most positive keys; order must be signed.
    task automatic test_extreme_keys();
        send_request(KIND_INSERT, 32'sh7FFF_FFFF);
        send_request(KIND_INSERT, 32'sh8000_0000);
        send_request(KIND_INSERT, '0);
        send_request(KIND_INSERT, '1);
        send_request(KIND_INSERT, 32'sh8000_0000);
        repeat (5)
            send_request(KIND_EXTRACT, '0);
    endtask

    // Equal keys: heapify picks the left of two equal children, and sift-up
    // stops at an equal parent.
    task automatic test_equal_keys();
        send_request(KIND_APPEND, 32'sd9);
        send_request(KIND_APPEND, 32'sd4);
        send_request(KIND_APPEND, 32'sd4);
        send_request(KIND_HEAPIFY, '0);
        send_request(KIND_INSERT, 32'sd4);
        repeat (4)
            send_request(KIND_EXTRACT, '0);
    endtask

    // Fill to capacity unsorted, hit the full case with both write kinds,
    // rebuild the largest heap, then drain past empty.
    task automatic test_capacity_limits();
        repeat (CAPACITY)
            send_request(KIND_APPEND, random_key());
        send_request(KIND_INSERT, random_key());
        send_request(KIND_APPEND, random_key());
        send_request(KIND_HEAPIFY, '0);
        repeat (CAPACITY + 1)
            send_request(KIND_EXTRACT, '0);
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so
    // the output register fills and the core stops taking requests.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        rsp_hold_request = 200;
        repeat (12)
            send_request(KIND_INSERT, random_key());
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        int          phase;
        int unsigned n;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(61, 0);
                2:       set_idling(0, 61);
                default: set_idling(35, 35);
            endcase
            for (n = 0; n < 60; n++)
                send_request(random_kind(n < 30), random_key());
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: ready pattern with an optional long hold-off, counted
    // here in cycles.
    // ------------------------------------------------------------------------
    initial
    begin : rsp_ready_driver
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_request != 0)
            begin
                hold_left        = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Each accepted response against the oldest pending prediction.
    always @(posedge clk)
    begin : result_checker
        heap_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"ERROR: %0t: response with no request pending: ",
                              "key_out=%0d status=%0d fill=%0d"},
                             $realtime, rsp_if.key_out, rsp_if.status, rsp_if.fill);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.key_out !== want.key_out || rsp_if.status !== want.status ||
                    rsp_if.fill !== want.fill)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"ERROR: %0t: expected key_out=%0d status=%0d fill=%0d, ",
                                  "got key_out=%0d status=%0d fill=%0d"},
                                 $realtime, want.key_out, want.status, want.fill,
                                 rsp_if.key_out, rsp_if.status, rsp_if.fill);
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin : watchdog
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.kind   <= KIND_INSERT;
        req_if.key_in <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_empty_heap();
        test_extreme_keys();
        test_equal_keys();
        set_idling(35, 35);
        test_capacity_limits();
        wait_for_drain();
        test_output_backpressure();
        test_random_mix();

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/bmh_pkg.sv
hdl/bmh_req_if.sv
hdl/bmh_rsp_if.sv
hdl/bmh_ram.sv
hdl/binary_min_heap_core.sv
tb/testbench.sv
